[rtl/core/pir_matvec_mod_q_macros.svh]
// Assertion macros used by the PIR matrix-vector product top level.
`ifndef PIR_MATVEC_MOD_Q_MACROS_SVH
`define PIR_MATVEC_MOD_Q_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PMVQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PMVQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pmvq_pkg.sv]
// Package: constants, types and modular helpers of the PIR matrix-vector block.
`default_nettype none

package pmvq_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int WORD_W    = 64;
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int ROW_W     = $clog2(MAX_SIDE);
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int AREA_W    = $clog2(DEPTH + 1);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_W - 1);

    // Request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_OOB    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 1'b1;

    // Commands broadcast to the accumulator cells
    typedef struct packed {
        logic shift_op;
        logic start;
        logic dbl;
        logic add;
        logic commit;
        logic rot;
    } t_cell_ctl;

    // (a + b) mod m for a, b below m; m of zero wraps at 2^64
    function automatic logic [WORD_W-1:0] addmod(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] gap;
        gap = m - b;
        if (m == '0)
            return a + b;
        else if (a >= gap)
            return a - gap;
        else
            return a + b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pmvq_req_if.sv]
// Request channel interface: valid/ready with the request payload.
`default_nettype none

interface pmvq_req_if;
    import pmvq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] index;
    logic [WORD_W-1:0] value;
    logic              last;

    modport source (output valid, req_type, index, value, last, input ready);
    modport sink   (input valid, req_type, index, value, last, output ready);
endinterface

`default_nettype wire

[rtl/core/pmvq_rsp_if.sv]
// Result channel interface: valid/ready with the result payload.
`default_nettype none

interface pmvq_rsp_if;
    import pmvq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] value_res;
    logic              last_res;

    modport source (output valid, kind, row, value_res, last_res, input ready);
    modport sink   (input valid, kind, row, value_res, last_res, output ready);
endinterface

`default_nettype wire

[rtl/core/pir_matvec_mod_q.sv]
// Top level: PIR server matrix-vector product modulo q over a chain of row cells.
//
//   channel   dir   handshake      payload
//   i_req     in    valid/ready    req_type, index, value, last
//   o_rsp     out   valid/ready    kind, row, value_res, last_res
//   cfg       in    i_cfg_we       i_cfg_idx, i_cfg_data
//
// A load is written as it is accepted; a read waits out any output stall.
// A query element on an in-range column, or marked last, is accepted and
// reduced modulo q, its sum with one is formed, the column streams out of
// the database RAM into the cells, all cells run the bit-serial
// multiply-accumulate side by side, and the new sums are committed.
// An element marked last then rotates the chain to emit the rows,
// each answer waiting while o_rsp is stalled. Reset is synchronous, active low.
`default_nettype none
`include "pir_matvec_mod_q_macros.svh"

module pir_matvec_mod_q import pmvq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pmvq_req_if.sink             i_req,
    pmvq_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_VRED   = 8'b0000_0010,
        ST_VSUM   = 8'b0000_0100,
        ST_LOAD   = 8'b0000_1000,
        ST_MAC    = 8'b0001_0000,
        ST_COMMIT = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_RD     = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [WORD_W-1:0]  r_q;
    logic [SIDE_W-1:0]  r_side;
    logic [AREA_W-1:0]  r_area;
    logic [ADDR_W-1:0]  r_addr;
    logic [SIDE_W-1:0]  r_cnt;
    logic [BIT_W-1:0]   r_bit;
    logic               r_ph;
    logic               r_last;
    logic               r_colok;
    logic               r_rdok;
    logic               r_rdin;
    logic [WORD_W-1:0]  r_vr;
    logic [WORD_W-1:0]  r_vsh;
    logic [WORD_W-1:0]  r_w;
    logic               r_ovld;
    logic [1:0]         r_okind;
    logic [ROW_W-1:0]   r_orow;
    logic [WORD_W-1:0]  r_oval;
    logic               r_olast;

    logic               req_acc;
    logic               out_free;
    logic               idx_in;
    logic               col_in;
    logic               emit_now;
    logic [WORD_W-1:0]  one_m;
    logic [WORD_W-1:0]  rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [SIDE_W-1:0]  cfg_side;
    t_cell_ctl          ctl;
    logic [WORD_W-1:0]  w_op  [MAX_SIDE+1];
    logic [WORD_W-1:0]  w_acc [MAX_SIDE+1];

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_ovld || o_rsp.ready;
    assign idx_in      = {1'b0, i_req.index} < r_area;
    assign col_in      = i_req.index < ADDR_W'(r_side);
    assign one_m       = (r_q == WORD_W'(1)) ? '0 : WORD_W'(1);
    assign emit_now    = (r_state == ST_EMIT) && (r_cnt < r_side) && out_free;

    // Clamp the side to 1..MAX_SIDE as it is written
    always_comb begin
        cfg_side = i_cfg_data[SIDE_W-1:0];
        if (cfg_side == '0) begin
            cfg_side = SIDE_W'(1);
        end else if (cfg_side > SIDE_W'(MAX_SIDE)) begin
            cfg_side = SIDE_W'(MAX_SIDE);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= WORD_W'(64'h1_0000_0000);
            r_side <= SIDE_W'(MAX_SIDE);
            r_area <= AREA_W'(DEPTH);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS: r_q <= i_cfg_data;
                CFG_SIDE: begin
                    r_side <= cfg_side;
                    r_area <= AREA_W'({{(AREA_W-SIDE_W){1'b0}}, cfg_side}
                                    * {{(AREA_W-SIDE_W){1'b0}}, cfg_side});
                end
                default: ;
            endcase
        end
    end

    // Database RAM: loads write in idle, column walks read at the running address
    assign ram_we   = req_acc && (i_req.req_type == REQ_LOAD) && idx_in;
    assign ram_addr = (r_state == ST_IDLE) ? i_req.index : r_addr;

    pmvq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_db (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_req.value),
        .o_rdata (rdata)
    );

    // Cell commands
    always_comb begin
        ctl          = '0;
        ctl.shift_op = (r_state == ST_LOAD) && (r_cnt != '0);
        ctl.start    = (r_state == ST_LOAD) && (r_cnt == SIDE_W'(MAX_SIDE));
        ctl.dbl      = (r_state == ST_MAC) && !r_ph;
        ctl.add      = (r_state == ST_MAC) && r_ph;
        ctl.commit   = (r_state == ST_COMMIT);
        ctl.rot      = (r_state == ST_EMIT) && ((r_cnt >= r_side) || out_free);
    end

    // Chain ends: column entries enter at the top, rotated rows wrap back unless emitted, when zero enters
    assign w_op[MAX_SIDE]  = r_rdok ? rdata : '0;
    assign w_acc[MAX_SIDE] = emit_now ? '0 : w_acc[0];

    for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
        pmvq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_en     (SIDE_W'(k) < r_side),
            .i_op_nb  (w_op[k+1]),
            .i_acc_nb (w_acc[k+1]),
            .i_q      (r_q),
            .i_v      (r_vr),
            .i_one    (one_m),
            .i_w      (r_w),
            .o_op     (w_op[k]),
            .o_acc    (w_acc[k])
        );
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rdok  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_rdok <= 1'b0;
                    if (req_acc) begin
                        r_addr <= i_req.index;
                        unique case (i_req.req_type)
                            REQ_QUERY: begin
                                r_vsh   <= i_req.value;
                                r_vr    <= '0;
                                r_last  <= i_req.last;
                                r_colok <= col_in;
                                r_bit   <= '0;
                                r_ph    <= 1'b0;
                                if (col_in || i_req.last) begin
                                    r_state <= ST_VRED;
                                end
                            end
                            REQ_READ: begin
                                r_rdin  <= idx_in;
                                r_state <= ST_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_VRED: begin
                    // Reduce the query element modulo q, one bit per double-and-add phase pair
                    r_ph <= !r_ph;
                    if (!r_ph) begin
                        r_vr <= addmod(r_vr, r_vr, r_q);
                    end else begin
                        if (r_vsh[WORD_W-1]) begin
                            r_vr <= addmod(r_vr, one_m, r_q);
                        end
                        r_vsh <= r_vsh << 1;
                        r_bit <= r_bit + BIT_W'(1);
                        if (r_bit == BIT_LAST) begin
                            r_state <= ST_VSUM;
                        end
                    end
                end
                ST_VSUM: begin
                    r_w     <= addmod(r_vr, one_m, r_q);
                    r_cnt   <= '0;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    // Walk the column row by row, feeding the cell chain
                    r_rdok <= (r_cnt < r_side) && r_colok;
                    r_addr <= r_addr + ADDR_W'(r_side);
                    r_cnt  <= r_cnt + SIDE_W'(1);
                    if (r_cnt == SIDE_W'(MAX_SIDE)) begin
                        r_bit   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_rdok <= 1'b0;
                    r_ph   <= !r_ph;
                    if (r_ph) begin
                        r_bit <= r_bit + BIT_W'(1);
                        if (r_bit == BIT_LAST) begin
                            r_state <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT: begin
                    r_cnt   <= '0;
                    r_state <= r_last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (ctl.rot) begin
                        r_cnt <= r_cnt + SIDE_W'(1);
                        if (r_cnt == SIDE_W'(MAX_SIDE - 1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_RD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (emit_now) begin
            r_ovld  <= 1'b1;
            r_okind <= KIND_ANSWER;
            r_orow  <= r_cnt[ROW_W-1:0];
            r_oval  <= w_acc[0];
            r_olast <= (r_cnt + SIDE_W'(1)) == r_side;
        end else if ((r_state == ST_RD) && out_free) begin
            r_ovld  <= 1'b1;
            r_okind <= r_rdin ? KIND_READ : KIND_OOB;
            r_orow  <= '0;
            r_oval  <= r_rdin ? rdata : '0;
            r_olast <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_rsp.valid     = r_ovld;
    assign o_rsp.kind      = r_okind;
    assign o_rsp.row       = r_orow;
    assign o_rsp.value_res = r_oval;
    assign o_rsp.last_res  = r_olast;

    `PMVQ_ASSERT_NXT(a_last_query_runs, req_acc && (i_req.req_type == REQ_QUERY) && i_req.last, r_state == ST_VRED, "last query element did not start a run")
    `PMVQ_ASSERT_NXT(a_commit_exit, r_state == ST_COMMIT, (r_state == ST_EMIT) || (r_state == ST_IDLE), "bad exit from commit")
    `PMVQ_ASSERT_IMP(a_only_answers_mid_run, r_ovld && !r_olast, r_okind == KIND_ANSWER, "non-final result is not an answer word")

endmodule

`default_nettype wire

[rtl/core/pmvq_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module pmvq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/pmvq_cell.sv]
// One row cell: holds a row accumulator and runs a bit-serial modular MAC.
`default_nettype none

module pmvq_cell import pmvq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic              i_en,
    input  logic [WORD_W-1:0] i_op_nb,
    input  logic [WORD_W-1:0] i_acc_nb,
    input  logic [WORD_W-1:0] i_q,
    input  logic [WORD_W-1:0] i_v,
    input  logic [WORD_W-1:0] i_one,
    input  logic [WORD_W-1:0] i_w,
    output logic [WORD_W-1:0] o_op,
    output logic [WORD_W-1:0] o_acc
);

    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_op;
    logic [WORD_W-1:0] r_res;
    logic [WORD_W-1:0] r_ash;
    logic [WORD_W-1:0] addend;

    // Pick the addend from the entry bit and the accumulator bit
    always_comb begin
        case ({r_op[WORD_W-1], r_ash[WORD_W-1]})
            2'b11:   addend = i_w;
            2'b10:   addend = i_v;
            2'b01:   addend = i_one;
            default: addend = '0;
        endcase
    end

    // Operand shift line and serial work registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_op) begin
            r_op <= i_op_nb;
        end else if (i_ctl.add) begin
            r_op <= r_op << 1;
        end
        if (i_ctl.start) begin
            r_res <= '0;
            r_ash <= r_acc;
        end else if (i_ctl.dbl) begin
            r_res <= addmod(r_res, r_res, i_q);
        end else if (i_ctl.add) begin
            r_res <= addmod(r_res, addend, i_q);
            r_ash <= r_ash << 1;
        end
    end

    // Accumulator: rotate for emission, commit the new sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.rot) begin
            r_acc <= i_acc_nb;
        end else if (i_ctl.commit && i_en) begin
            r_acc <= r_res;
        end
    end

    assign o_op  = r_op;
    assign o_acc = r_acc;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the PIR matrix-vector product block modulo q.
`default_nettype none

module testbench;
    import pmvq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    // Request code that the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_MODE} t_step_op;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        t_step_op             op;
        logic [1:0]           rt;
        logic [ADDR_W-1:0]    idx;
        logic [WORD_W-1:0]    val;
        logic                 last;
        logic [CFG_IDX_W-1:0] cfg_idx;
        t_idle_mode           mode;
    } t_step;

    typedef struct {
        logic [1:0]        kind;
        logic [ROW_W-1:0]  row;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    pmvq_req_if req_if();
    pmvq_rsp_if rsp_if();

    pir_matvec_mod_q dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state
    logic [WORD_W-1:0] db_copy [DEPTH];
    logic [WORD_W-1:0] row_sum [MAX_SIDE];
    logic [WORD_W-1:0] mod_q = 64'h1_0000_0000;
    logic [6:0] side_reg = 7'd64;

    // Entries that the plan has written so far
    bit gen_written [DEPTH];

    t_step   plan_q[$];
    t_answer answer_q[$];
    int errors = 0;
    int watchdog = 0;
    int settle_cnt = 0;
    bit req_fire = 1'b0;
    bit drv_done = 1'b0;
    t_idle_mode idle_mode = IDLE_NONE;

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.index = '0;
        req_if.value = '0;
        req_if.last = 1'b0;
        rsp_if.ready = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic int unsigned side_eff();
        if (side_reg == 0) return 1;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    function automatic logic [WORD_W-1:0] reduce_q(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] q);
        return (q == 0) ? a : a % q;
    endfunction

    function automatic logic [WORD_W-1:0] mul_q(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] q);
        logic [127:0] prod;
        if (q == 0) return a * b;
        prod = 128'(a % q) * 128'(b % q);
        return 64'(prod % 128'(q));
    endfunction

    function automatic logic [WORD_W-1:0] add_q(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] q);
        logic [64:0] sum;
        if (q == 0) return a + b;
        sum = 65'(a) + 65'(b);
        return 64'(sum % 65'(q));
    endfunction

    // Work out the results of one accepted request
    task automatic predict_request(input logic [1:0] rt, input logic [ADDR_W-1:0] idx,
                                   input logic [WORD_W-1:0] val, input logic last);
        int unsigned s;
        bit in_range;
        t_answer a;
        s = side_eff();
        in_range = (idx < s * s);
        if (rt == REQ_LOAD) begin
            if (in_range) db_copy[idx] = val;
        end else if (rt == REQ_READ) begin
            a.kind = in_range ? KIND_READ : KIND_OOB;
            a.row = '0;
            a.value = in_range ? db_copy[idx] : '0;
            a.last = 1'b1;
            answer_q.insert(answer_q.size(), a);
        end else if (rt == REQ_QUERY) begin
            if (idx < s) begin
                for (int i = 0; i < s; i++)
                    row_sum[i] = add_q(reduce_q(row_sum[i], mod_q),
                                       mul_q(db_copy[i * s + idx], val, mod_q), mod_q);
            end
            if (last) begin
                for (int i = 0; i < s; i++) begin
                    a.kind = KIND_ANSWER;
                    a.row = ROW_W'(i);
                    a.value = reduce_q(row_sum[i], mod_q);
                    a.last = (i + 1 == s);
                    answer_q.insert(answer_q.size(), a);
                    row_sum[i] = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Monitor: sample transactions and config writes at the rising edge
    always @(posedge i_clk) begin
        t_answer w;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_we) begin
                moved = 1'b1;
                if (cfg_idx == CFG_MODULUS) mod_q = cfg_data;
                else if (cfg_idx == CFG_SIDE) side_reg = cfg_data[6:0];
            end
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                predict_request(req_if.req_type, req_if.index, req_if.value, req_if.last);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result", rsp_if.value_res, '0);
                end else begin
                    w = answer_q.pop_front();
                    if (rsp_if.kind !== w.kind) report_mismatch("kind", rsp_if.kind, w.kind);
                    if (rsp_if.row !== w.row) report_mismatch("row", rsp_if.row, w.row);
                    if (rsp_if.value_res !== w.value)
                        report_mismatch("value_res", rsp_if.value_res, w.value);
                    if (rsp_if.last_res !== w.last)
                        report_mismatch("last_res", rsp_if.last_res, w.last);
                end
            end
        end
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        watchdog = moved ? 0 : watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Driver: feed the plan at the falling edge
    always @(negedge i_clk) begin
        t_step st;
        logic v_valid;
        logic v_we;
        logic v_ready;
        v_valid = 1'b0;
        v_we = 1'b0;
        v_ready = !((idle_mode == IDLE_RECV) && ($urandom_range(99) < 48)) &&
                  !((idle_mode == IDLE_BOTH) && ($urandom_range(99) < 18));
        if (!i_rst_n) begin
            v_ready = 1'b0;
        end else if (req_if.valid && !req_fire) begin
            // hold until accepted
            v_valid = 1'b1;
        end else if (plan_q.size() == 0) begin
            drv_done <= 1'b1;
        end else begin
            st = plan_q[0];
            case (st.op)
                STEP_MODE: begin
                    idle_mode <= st.mode;
                    void'(plan_q.pop_front());
                end
                STEP_DRAIN: begin
                    if (answer_q.size() == 0) begin
                        if (settle_cnt >= SETTLE_CYCLES) begin
                            settle_cnt = 0;
                            void'(plan_q.pop_front());
                        end else begin
                            settle_cnt++;
                        end
                    end
                end
                STEP_CFG: begin
                    v_we = 1'b1;
                    cfg_idx <= st.cfg_idx;
                    cfg_data <= st.val;
                    void'(plan_q.pop_front());
                end
                default: begin
                    if (!((idle_mode == IDLE_SEND) && ($urandom_range(99) < 48)) &&
                        !((idle_mode == IDLE_BOTH) && ($urandom_range(99) < 18))) begin
                        v_valid = 1'b1;
                        req_if.req_type <= st.rt;
                        req_if.index <= st.idx;
                        req_if.value <= st.val;
                        req_if.last <= st.last;
                        void'(plan_q.pop_front());
                    end
                end
            endcase
        end
        req_if.valid <= v_valid;
        cfg_we <= v_we;
        rsp_if.ready <= v_ready;
    end

    task automatic push_req(input logic [1:0] rt, input int unsigned idx,
                            input logic [WORD_W-1:0] val, input logic last);
        t_step st;
        st.op = STEP_REQ;
        st.rt = rt;
        st.idx = ADDR_W'(idx);
        st.val = val;
        st.last = last;
        st.cfg_idx = '0;
        st.mode = IDLE_NONE;
        plan_q.insert(plan_q.size(), st);
    endtask

    task automatic push_ctl(input t_step_op op, input logic [CFG_IDX_W-1:0] ci,
                            input logic [WORD_W-1:0] data, input t_idle_mode m);
        t_step st;
        st.op = op;
        st.rt = '0;
        st.idx = '0;
        st.val = data;
        st.last = 1'b0;
        st.cfg_idx = ci;
        st.mode = m;
        plan_q.insert(plan_q.size(), st);
    endtask

    // Queue a load and mark the entry written when it lands inside the area
    task automatic add_load(input int unsigned s, input int unsigned idx,
                            input logic [WORD_W-1:0] val);
        push_req(REQ_LOAD, idx, val, 1'($urandom_range(1)));
        if (idx < s * s) gen_written[idx] = 1'b1;
    endtask

    // A column is safe to query once every row of it is written
    function automatic bit col_ready(input int unsigned s, input int unsigned col);
        for (int i = 0; i < s; i++)
            if (!gen_written[i * s + col]) return 1'b0;
        return 1'b1;
    endfunction

    // Keep a wanted column when it is safe, else fall back to one out of range
    function automatic int unsigned query_col(input int unsigned s, input int unsigned want);
        if (want < s && col_ready(s, want)) return want;
        return $urandom_range(4095, s);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value(input logic [WORD_W-1:0] q);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return q - 1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Drain, configure, fill some whole columns, optionally add directed requests, then mix random ones
    task automatic run_phase(input logic [WORD_W-1:0] q, input logic [6:0] side,
                             input t_idle_mode m, input int n_items, input int n_cols,
                             input bit directed);
        int unsigned s;
        int unsigned area;
        int unsigned len;
        int unsigned col;
        int unsigned base;
        int unsigned ready_q[$];
        int cnt;
        int r;
        s = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
        area = s * s;
        push_ctl(STEP_DRAIN, CFG_MODULUS, '0, IDLE_NONE);
        push_ctl(STEP_CFG, CFG_MODULUS, q, IDLE_NONE);
        push_ctl(STEP_CFG, CFG_SIDE, {$urandom, 25'($urandom), side}, IDLE_NONE);
        push_ctl(STEP_MODE, CFG_MODULUS, '0, m);
        base = $urandom_range(s - 1);
        for (int c = 0; c < n_cols && c < s; c++) begin
            col = (base + c) % s;
            for (int i = 0; i < s; i++) add_load(s, i * s + col, pick_value(q));
        end
        if (directed) begin
            add_load(s, 0, '1);
            add_load(s, area - 1, '0);
            push_req(REQ_READ, 0, '0, 1'b1);
            push_req(REQ_READ, area - 1, '1, 1'b0);
            push_req(REQ_UNUSED, 4095, '1, 1'b1);
            add_load(s, 4095, '1);
            push_req(REQ_READ, 4095, '0, 1'b0);
            push_req(REQ_QUERY, query_col(s, 0), '1, 1'b0);
            push_req(REQ_QUERY, query_col(s, s - 1), '0, 1'b0);
            push_req(REQ_QUERY, 4095, '1, 1'b1);
            push_req(REQ_QUERY, query_col(s, s - 1), q - 1, 1'b1);
            push_req(REQ_QUERY, query_col(s, 0), {$urandom, $urandom}, 1'b1);
        end
        for (int c = 0; c < s; c++)
            if (col_ready(s, c)) ready_q.insert(ready_q.size(), c);
        cnt = 0;
        while (cnt < n_items) begin
            r = $urandom_range(99);
            if (r < 50) begin
                // well-formed query vector, mostly on fully written columns
                len = $urandom_range(1, (s < 6) ? s + 1 : 6);
                for (int k = 0; k < len; k++) begin
                    col = (ready_q.size() != 0 && $urandom_range(9) != 0)
                        ? ready_q[$urandom_range(ready_q.size() - 1)]
                        : $urandom_range(4095, s);
                    push_req(REQ_QUERY, col, pick_value(q), k == len - 1);
                end
                cnt += len;
            end else if (r < 70) begin
                if (area < DEPTH && (ready_q.size() == 0 || $urandom_range(3) == 0)) begin
                    push_req(REQ_READ, $urandom_range(4095, area), pick_value(q),
                             1'($urandom_range(1)));
                end else if (ready_q.size() != 0) begin
                    col = ready_q[$urandom_range(ready_q.size() - 1)];
                    push_req(REQ_READ, $urandom_range(s - 1) * s + col, pick_value(q),
                             1'($urandom_range(1)));
                end else begin
                    push_req(REQ_UNUSED, $urandom_range(4095), pick_value(q),
                             1'($urandom_range(1)));
                end
                cnt++;
            end else if (r < 85) begin
                add_load(s, $urandom_range(4095), pick_value(q));
                cnt++;
            end else begin
                push_req(REQ_UNUSED, $urandom_range(4095), pick_value(q),
                         1'($urandom_range(1)));
                cnt++;
            end
        end
    endtask

    initial begin
        run_phase(64'h1_0000_0000, 7'd64, IDLE_NONE, 14, 1, 1'b0);
        run_phase(64'd0, 7'd0, IDLE_SEND, 14, 1, 1'b1);
        run_phase('1, 7'd127, IDLE_RECV, 10, 0, 1'b0);
        run_phase(64'd1, 7'd3, IDLE_BOTH, 16, 3, 1'b1);
        run_phase(64'd97, 7'd5, IDLE_NONE, 18, 3, 1'b0);
        run_phase({$urandom, $urandom} | 64'd1, 7'd8, IDLE_SEND, 18, 2, 1'b0);
        run_phase(64'(20'($urandom)) | 64'd3, 7'd16, IDLE_RECV, 14, 1, 1'b0);
        run_phase({1'b1, 31'($urandom), $urandom}, 7'd7, IDLE_BOTH, 18, 2, 1'b0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(drv_done && answer_q.size() == 0)) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
